FILE: rtl/dpa_pkg.sv
// Package for the dining-philosophers ring arbiter.
// Holds field widths, command and result codes, controller states and the
// command/status structs that join the controller and datapath.
`default_nettype none

package dpa_pkg;

   // Field widths of the request and response beats
   localparam int CMD_W  = 2;
   localparam int SEAT_W = 4;
   localparam int KIND_W = 2;
   localparam int OCC_W  = 5;

   // Ring configuration
   localparam int MAX_SEATS_DEFAULT = 16;
   localparam int MIN_REMOVE_INDEX  = 2;
   localparam int INITIAL_SEATS     = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_REQUEST = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_ADD     = 2'd2,
      CMD_REMOVE  = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GRANT = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_THINK = 2'd0,
      ST_EAT   = 2'd1,
      ST_WAIT  = 2'd2
   } seat_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_REMOVE,
      S_CHK0,
      S_CHK1,
      S_CHK2,
      S_ERROR,
      S_EMIT0,
      S_EMIT1
   } state_type;

   // Seat to load into the check register
   typedef enum logic [2:0] {
      CHK_SEAT,
      CHK_LEFT,
      CHK_RIGHT,
      CHK_BELOW_LAST,
      CHK_ZERO
   } chk_src_type;

   // Address for the second memory read port
   typedef enum logic [1:0] {
      RD_LEFT,
      RD_RIGHT,
      RD_LAST
   } rd_src_type;

   // Address for the memory write port
   typedef enum logic [1:0] {
      WR_SEAT,
      WR_CHK,
      WR_COUNT,
      WR_LAST
   } wr_src_type;

   typedef enum logic [1:0] {
      RSP_ERROR,
      RSP_FIRST,
      RSP_SECOND
   } rsp_src_type;

   typedef struct packed {
      logic           req_load;
      logic           chk_load;
      chk_src_type    chk_src;
      rd_src_type     rd_src;
      logic           hold_chk;
      logic           wr_en;
      wr_src_type     wr_src;
      seat_state_type wr_data;
      logic           cnt_inc;
      logic           cnt_dec;
      logic           grant_clr;
      logic           grant_push;
      logic           rsp_load;
      rsp_src_type    rsp_src;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    seat_err;
      logic    add_full;
      logic    rmv_few;
      logic    last_eats;
      logic    grant_ok;
      logic    two_grants;
      logic    rsp_room;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/dpa_datapath.sv
// Datapath of the ring arbiter: seat-state memory, seat count, check and
// grant registers and the response output register. Depends on dpa_pkg.
`default_nettype none

module dpa_datapath #(
   parameter int MAX_SEATS = dpa_pkg::MAX_SEATS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [dpa_pkg::CMD_W-1:0]  req_command,
   input  logic [dpa_pkg::SEAT_W-1:0] req_seat,
   input  dpa_pkg::ctl_type           ctl,
   output dpa_pkg::sts_type           sts,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dpa_pkg::KIND_W-1:0] rsp_kind,
   output logic [dpa_pkg::SEAT_W-1:0] rsp_granted_seat,
   output logic [dpa_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                       rsp_last
);
   import dpa_pkg::*;

   localparam int IW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int CW = $clog2(MAX_SEATS + 1);
   localparam int XW = ((CW > SEAT_W) ? CW : SEAT_W) + 1;
   localparam int INIT_CNT = (INITIAL_SEATS > MAX_SEATS) ? MAX_SEATS : INITIAL_SEATS;

   cmd_type             cmd_ff;
   logic [SEAT_W-1:0]   seat_ff;
   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       chk_ff;
   logic [IW-1:0]       chk_in;
   logic                chk_wait_ff;
   logic                left_eat_ff;
   logic [IW-1:0]       g0_ff;
   logic [IW-1:0]       g1_ff;
   logic [1:0]          ngr_ff;
   seat_state_type      mem [MAX_SEATS];
   logic [MAX_SEATS-1:0] valid_ff;
   seat_state_type      rd0_ff;
   seat_state_type      rd1_ff;
   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       wr_addr;
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [IW-1:0]       rsp_seat_ff;
   logic [OCC_W-1:0]    rsp_occ_ff;
   logic                rsp_last_ff;
   logic [XW-1:0]       count_x;
   logic [XW-1:0]       seat_x;
   logic [XW-1:0]       chk_x;

   function automatic logic [XW-1:0] left_of(input logic [XW-1:0] s, input logic [XW-1:0] n);
      return (s == '0) ? n - XW'(1) : s - XW'(1);
   endfunction

   function automatic logic [XW-1:0] right_of(input logic [XW-1:0] s, input logic [XW-1:0] n);
      return (s + XW'(1) >= n) ? '0 : s + XW'(1);
   endfunction

   assign count_x = XW'(count_ff);
   assign seat_x  = XW'(seat_ff);
   assign chk_x   = XW'(chk_ff);

   // Status toward the controller
   assign sts.cmd        = cmd_ff;
   assign sts.seat_err   = seat_x >= count_x;
   assign sts.add_full   = count_x >= XW'(MAX_SEATS);
   assign sts.rmv_few    = count_x < XW'(MIN_REMOVE_INDEX + 1);
   assign sts.last_eats  = rd1_ff == ST_EAT;
   assign sts.grant_ok   = chk_wait_ff && !left_eat_ff && (rd1_ff != ST_EAT);
   assign sts.two_grants = ngr_ff == 2'd2;
   assign sts.rsp_room   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (ctl.chk_src)
         CHK_SEAT:       chk_in = IW'(seat_ff);
         CHK_LEFT:       chk_in = IW'(left_of(seat_x, count_x));
         CHK_RIGHT:      chk_in = IW'(right_of(seat_x, count_x));
         CHK_BELOW_LAST: chk_in = IW'(count_x - XW'(2));
         default:        chk_in = '0;
      endcase
   end

   always_comb begin
      unique case (ctl.rd_src)
         RD_LEFT:  rd_addr = IW'(left_of(chk_x, count_x));
         RD_RIGHT: rd_addr = IW'(right_of(chk_x, count_x));
         default:  rd_addr = IW'(count_x - XW'(1));
      endcase
   end

   always_comb begin
      unique case (ctl.wr_src)
         WR_SEAT:  wr_addr = IW'(seat_ff);
         WR_CHK:   wr_addr = chk_ff;
         WR_COUNT: wr_addr = IW'(count_ff);
         default:  wr_addr = IW'(count_x - XW'(1));
      endcase
   end

   // Seat-state memory; entries never written since reset read as thinking
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      rd0_ff <= valid_ff[chk_ff]  ? mem[chk_ff]  : ST_THINK;
      rd1_ff <= valid_ff[rd_addr] ? mem[rd_addr] : ST_THINK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(INIT_CNT);
         ngr_ff   <= '0;
      end else begin
         if (ctl.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (ctl.cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end
         if (ctl.grant_clr) begin
            ngr_ff <= '0;
         end else if (ctl.grant_push) begin
            ngr_ff <= ngr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         cmd_ff  <= cmd_type'(req_command);
         seat_ff <= req_seat;
      end
      if (ctl.chk_load) begin
         chk_ff <= chk_in;
      end
      if (ctl.hold_chk) begin
         chk_wait_ff <= rd0_ff == ST_WAIT;
         left_eat_ff <= rd1_ff == ST_EAT;
      end
      if (ctl.grant_push) begin
         if (ngr_ff == 2'd0) begin
            g0_ff <= chk_ff;
         end else begin
            g1_ff <= chk_ff;
         end
      end
   end

   // Response register: take a new beat only when the old one is gone
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         // hold the count with the beat; the next command may move it
         rsp_occ_ff <= OCC_W'(count_ff);
         case (ctl.rsp_src)
            RSP_FIRST: begin
               if (ngr_ff == 2'd0) begin
                  rsp_kind_ff <= KIND_DONE;
                  rsp_seat_ff <= '0;
                  rsp_last_ff <= 1'b1;
               end else begin
                  rsp_kind_ff <= KIND_GRANT;
                  rsp_seat_ff <= g0_ff;
                  rsp_last_ff <= ngr_ff == 2'd1;
               end
            end
            RSP_SECOND: begin
               rsp_kind_ff <= KIND_GRANT;
               rsp_seat_ff <= g1_ff;
               rsp_last_ff <= 1'b1;
            end
            default: begin
               rsp_kind_ff <= KIND_ERROR;
               rsp_seat_ff <= '0;
               rsp_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_granted_seat = SEAT_W'(rsp_seat_ff);
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_last         = rsp_last_ff;

   a_grant_count : assert property (@(posedge clock) disable iff (reset)
      ngr_ff != 2'd3)
      else $error("more than two grants recorded for one command");

   a_wr_range : assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> (XW'(wr_addr) < XW'(MAX_SEATS)))
      else $error("seat-state write beyond the ring");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_x <= XW'(MAX_SEATS))
      else $error("seat count above its maximum");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> sts.rsp_room)
      else $error("response beat loaded over one not yet taken");

endmodule

`default_nettype wire

FILE: rtl/dpa_controller.sv
// Controller of the ring arbiter: sequences decode, memory reads, neighbor
// checks and response beats. Depends on dpa_pkg.
`default_nettype none

module dpa_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpa_pkg::sts_type sts,
   output dpa_pkg::ctl_type ctl
);
   import dpa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      second_ff;
   logic      second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      second_in = second_ff;
      req_stall = state_ff != S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.req_load  = 1'b1;
               ctl.grant_clr = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            // prefetch the last seat for a remove
            ctl.rd_src = RD_LAST;
            unique case (sts.cmd)
               CMD_REQUEST: begin
                  if (sts.seat_err) begin
                     state_in = S_ERROR;
                  end else begin
                     ctl.wr_en    = 1'b1;
                     ctl.wr_src   = WR_SEAT;
                     ctl.wr_data  = ST_WAIT;
                     ctl.chk_load = 1'b1;
                     ctl.chk_src  = CHK_SEAT;
                     second_in    = 1'b0;
                     state_in     = S_CHK0;
                  end
               end
               CMD_RELEASE: begin
                  if (sts.seat_err) begin
                     state_in = S_ERROR;
                  end else begin
                     ctl.wr_en    = 1'b1;
                     ctl.wr_src   = WR_SEAT;
                     ctl.wr_data  = ST_THINK;
                     ctl.chk_load = 1'b1;
                     ctl.chk_src  = CHK_LEFT;
                     second_in    = 1'b1;
                     state_in     = S_CHK0;
                  end
               end
               CMD_ADD: begin
                  if (sts.add_full) begin
                     state_in = S_ERROR;
                  end else begin
                     ctl.wr_en   = 1'b1;
                     ctl.wr_src  = WR_COUNT;
                     ctl.wr_data = ST_THINK;
                     ctl.cnt_inc = 1'b1;
                     state_in    = S_EMIT0;
                  end
               end
               default: begin
                  if (sts.rmv_few) begin
                     state_in = S_ERROR;
                  end else begin
                     state_in = S_REMOVE;
                  end
               end
            endcase
         end
         S_REMOVE: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_src  = WR_LAST;
            ctl.wr_data = ST_THINK;
            ctl.cnt_dec = 1'b1;
            if (sts.last_eats) begin
               ctl.chk_load = 1'b1;
               ctl.chk_src  = CHK_BELOW_LAST;
               second_in    = 1'b1;
               state_in     = S_CHK0;
            end else begin
               state_in = S_EMIT0;
            end
         end
         S_CHK0: begin
            ctl.rd_src = RD_LEFT;
            state_in   = S_CHK1;
         end
         S_CHK1: begin
            ctl.hold_chk = 1'b1;
            ctl.rd_src   = RD_RIGHT;
            state_in     = S_CHK2;
         end
         S_CHK2: begin
            if (sts.grant_ok) begin
               ctl.wr_en      = 1'b1;
               ctl.wr_src     = WR_CHK;
               ctl.wr_data    = ST_EAT;
               ctl.grant_push = 1'b1;
            end
            if (second_ff) begin
               second_in    = 1'b0;
               ctl.chk_load = 1'b1;
               ctl.chk_src  = (sts.cmd == CMD_RELEASE) ? CHK_RIGHT : CHK_ZERO;
               state_in     = S_CHK0;
            end else begin
               state_in = S_EMIT0;
            end
         end
         S_ERROR: begin
            if (sts.rsp_room) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_src  = RSP_ERROR;
               state_in     = S_IDLE;
            end
         end
         S_EMIT0: begin
            if (sts.rsp_room) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_src  = RSP_FIRST;
               state_in     = sts.two_grants ? S_EMIT1 : S_IDLE;
            end
         end
         S_EMIT1: begin
            if (sts.rsp_room) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_src  = RSP_SECOND;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/dining_philosophers_arbiter_core.sv
// Top level of the dining-philosophers ring arbiter.
// Joins dpa_controller and dpa_datapath; depends on dpa_pkg.
//
//   channel | direction | handshake          | beat contents
//   req_    | in        | req_valid/stall    | command, seat
//   rsp_    | out       | rsp_valid/stall    | kind, granted_seat, occupancy, last
//
// One command at a time. Errors and add go from accept to the response beat
// with no neighbor check; a remove passes through its remove state; a request
// makes one neighbor check; a release and a remove with re-checks make two.
// A second grant adds one beat. The check time is set by the seat-state memory:
// one write port and two registered read ports, three reads per neighbor check.
// Synchronous reset restores the initial seat count and marks all seats thinking.
// rsp_stall holds the controller in error/emit states; req_stall is high while busy.
`default_nettype none

module dining_philosophers_arbiter_core #(
   parameter int MAX_SEATS = dpa_pkg::MAX_SEATS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dpa_pkg::CMD_W-1:0]  req_command,
   input  logic [dpa_pkg::SEAT_W-1:0] req_seat,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dpa_pkg::KIND_W-1:0] rsp_kind,
   output logic [dpa_pkg::SEAT_W-1:0] rsp_granted_seat,
   output logic [dpa_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                       rsp_last
);
   import dpa_pkg::*;

   ctl_type ctl;
   sts_type sts;

   dpa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   dpa_datapath #(
      .MAX_SEATS (MAX_SEATS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_seat         (req_seat),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_granted_seat (rsp_granted_seat),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
